/* rtl/asl_pkg.sv */
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants of the aligned segment locator.
// ----------------------------------------------------------------------------
package asl_pkg;

	localparam int unsigned MAX_SEGS_DEF = 1024;
	localparam int unsigned LEN_W        = 32;
	localparam int unsigned IDX_W        = 10;
	localparam int unsigned END_W        = 33;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_EMPTY = 2'd2,
		STS_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		logic init;
		logic step;
	} srch_ctl_t;

endpackage

/* rtl/asl_req_if.sv */
// ----------------------------------------------------------------------------
// asl_req_if
// Request channel: one action word per handshake.
// ----------------------------------------------------------------------------
interface asl_req_if import asl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       action;
	logic [LEN_W-1:0] seg_len;
	logic             anchor_has_seq;
	logic [LEN_W-1:0] aln_pos;

	modport source (output valid, action, seg_len, anchor_has_seq, aln_pos, input ready);
	modport sink   (input valid, action, seg_len, anchor_has_seq, aln_pos, output ready);
endinterface

/* rtl/asl_rsp_if.sv */
// ----------------------------------------------------------------------------
// asl_rsp_if
// Response channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface asl_rsp_if import asl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] seg_index;
	logic [IDX_W-1:0] raw_seg_index;
	logic [LEN_W-1:0] seg_start;
	logic [LEN_W-1:0] pos_offset;

	modport source (output valid, status, seg_index, raw_seg_index, seg_start, pos_offset,
		input ready);
	modport sink   (input valid, status, seg_index, raw_seg_index, seg_start, pos_offset,
		output ready);
endinterface

/* rtl/asl_table.sv */
// ----------------------------------------------------------------------------
// asl_table
// Segment table: start and raw index per aligned segment, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module asl_table import asl_pkg::*; #(
	parameter int unsigned DEPTH = MAX_SEGS_DEF,
	parameter int unsigned AW    = $clog2(MAX_SEGS_DEF)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [LEN_W-1:0] wstart,
	input  logic [IDX_W-1:0] wraw,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [LEN_W-1:0] rstart,
	output logic [IDX_W-1:0] rraw
);

	logic [LEN_W-1:0] start_mem [DEPTH];
	logic [IDX_W-1:0] raw_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			start_mem[waddr] <= wstart;
			raw_mem[waddr]   <= wraw;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rstart <= start_mem[raddr];
			rraw   <= raw_mem[raddr];
		end
	end

endmodule

/* rtl/asl_search.sv */
// ----------------------------------------------------------------------------
// asl_search
// Binary search step unit: one compare of a fetched start to the position
// per cycle while stepped, narrowing lo/hi, issuing the next probe address.
// ----------------------------------------------------------------------------
module asl_search import asl_pkg::*; #(
	parameter int unsigned AW = $clog2(MAX_SEGS_DEF)
) (
	input  logic             clk,
	input  srch_ctl_t        ctl,
	input  logic [AW-1:0]    last_idx,
	input  logic [LEN_W-1:0] pos,
	input  logic [LEN_W-1:0] rd_start,
	output logic [AW-1:0]    raddr,
	output logic             done,
	output logic [AW-1:0]    lo
);

	logic [AW-1:0] lo_q, hi_q, mid_q;
	logic [AW-1:0] lo_n, hi_n, mid_n;
	logic [AW:0]   span;

	always_comb begin
		lo_n = lo_q;
		hi_n = hi_q;
		if (ctl.init) begin
			lo_n = '0;
			hi_n = last_idx;
		end else if (ctl.step) begin
			if (rd_start <= pos) begin
				lo_n = mid_q;
			end else begin
				hi_n = mid_q - AW'(1);
			end
		end
		span  = {1'b0, hi_n} - {1'b0, lo_n} + (AW+1)'(1);
		mid_n = lo_n + AW'(span >> 1);
		done  = !(lo_n < hi_n);
		raddr = done ? lo_n : mid_n;
	end

	always_ff @(posedge clk) begin
		if (ctl.init || ctl.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	assign lo = lo_q;

endmodule

/* rtl/aligned_segment_locator.sv */
// ----------------------------------------------------------------------------
// aligned_segment_locator
// Builds a table of aligned segment starts from raw segment lengths and
// locates alignment positions in it by binary search.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one action word (clear, load, query); rsp returns exactly
//   one result word per request, in order.
//   cfg_we/cfg_wdata write anchor_set; write it only while idle.
//   Clear, load, unused codes and rejected queries: the result is registered
//   at acceptance and shows on rsp the next cycle.
//   Query that searches: one table probe per cycle in the search state,
//   then the fetch state registers the result onto rsp, and the next
//   request is taken only once the fetch state has returned to idle;
//   the table's single read port sets the probe rate.
//   One request at a time: req.ready is high only while no search runs and
//   the result register is empty or being taken.
//   A stalled rsp holds its word; a finished search waits in the fetch state.
//   Reset empties the table (counts and running end to zero) and clears
//   anchor_set; no clearing pass is needed.
// ----------------------------------------------------------------------------
module aligned_segment_locator import asl_pkg::*; #(
	parameter int unsigned MAX_SEGS = MAX_SEGS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	asl_req_if.sink   req,
	asl_rsp_if.source rsp
);

	localparam int unsigned AW = $clog2(MAX_SEGS);
	localparam int unsigned CW = $clog2(MAX_SEGS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_FETCH  = 3'b100
	} state_t;

	state_t           state_q;
	logic             anchor_q;
	logic [CW-1:0]    aligned_cnt_q, raw_cnt_q;
	logic [END_W-1:0] run_end_q;
	logic [LEN_W-1:0] pos_q;

	logic             ov_q;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] seg_index_q, raw_index_q;
	logic [LEN_W-1:0] seg_start_q, pos_offset_q;

	logic             acc, slot_free, counted, full, ovf, empty, out_range, store;
	logic [END_W:0]   end_sum;
	logic [1:0]       r_status;
	logic [IDX_W-1:0] r_seg_index, r_raw_index;
	logic [LEN_W-1:0] r_seg_start;
	srch_ctl_t        sctl;
	logic [AW-1:0]    raddr, lo;
	logic             sdone;
	logic [LEN_W-1:0] rd_start;
	logic [IDX_W-1:0] rd_raw;
	logic             fetch_out;

	assign slot_free = !ov_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && slot_free;
	assign acc       = req.valid && req.ready;

	assign counted   = !anchor_q || req.anchor_has_seq;
	assign full      = raw_cnt_q >= CW'(MAX_SEGS);
	assign end_sum   = {1'b0, run_end_q} + {2'b00, req.seg_len};
	assign ovf       = run_end_q[END_W-1] || (end_sum > (END_W+1)'(34'h1_0000_0000));
	assign empty     = aligned_cnt_q == '0;
	assign out_range = {1'b0, req.aln_pos} >= run_end_q;
	assign store     = acc && (req.action == ACT_LOAD) && !full && counted && !ovf;

	assign sctl.init = acc && (req.action == ACT_QUERY) && !empty && !out_range;
	assign sctl.step = state_q == ST_SEARCH;
	assign fetch_out = (state_q == ST_FETCH) && slot_free;

	always_comb begin
		r_status    = STS_OK;
		r_seg_index = '0;
		r_raw_index = '0;
		r_seg_start = '0;
		unique case (req.action)
			ACT_CLEAR: begin
			end
			ACT_LOAD: begin
				if (full || (counted && ovf)) begin
					r_status = STS_FULL;
				end else if (counted) begin
					r_seg_index = IDX_W'(aligned_cnt_q);
					r_raw_index = IDX_W'(raw_cnt_q);
					r_seg_start = run_end_q[LEN_W-1:0];
				end else begin
					r_raw_index = IDX_W'(raw_cnt_q);
				end
			end
			ACT_QUERY: begin
				if (empty) begin
					r_status = STS_EMPTY;
				end else if (out_range) begin
					r_status = STS_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	asl_table #(.DEPTH(MAX_SEGS), .AW(AW)) u_table (
		.clk    (clk),
		.we     (store),
		.waddr  (aligned_cnt_q[AW-1:0]),
		.wstart (run_end_q[LEN_W-1:0]),
		.wraw   (IDX_W'(raw_cnt_q)),
		.re     (sctl.init || sctl.step),
		.raddr  (raddr),
		.rstart (rd_start),
		.rraw   (rd_raw)
	);

	asl_search #(.AW(AW)) u_search (
		.clk      (clk),
		.ctl      (sctl),
		.last_idx (AW'(aligned_cnt_q - CW'(1))),
		.pos      (pos_q),
		.rd_start (rd_start),
		.raddr    (raddr),
		.done     (sdone),
		.lo       (lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			anchor_q      <= 1'b0;
			aligned_cnt_q <= '0;
			raw_cnt_q     <= '0;
			run_end_q     <= '0;
			ov_q          <= 1'b0;
		end else begin
			if (cfg_we) begin
				anchor_q <= cfg_wdata;
			end
			if (acc && (req.action == ACT_CLEAR)) begin
				aligned_cnt_q <= '0;
				raw_cnt_q     <= '0;
				run_end_q     <= '0;
			end else if (acc && (req.action == ACT_LOAD) && !full) begin
				if (!counted) begin
					raw_cnt_q <= raw_cnt_q + CW'(1);
				end else if (!ovf) begin
					raw_cnt_q     <= raw_cnt_q + CW'(1);
					aligned_cnt_q <= aligned_cnt_q + CW'(1);
					run_end_q     <= end_sum[END_W-1:0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (sctl.init) begin
						state_q <= sdone ? ST_FETCH : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (sdone) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if ((acc && !sctl.init) || fetch_out) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sctl.init) begin
			pos_q <= req.aln_pos;
		end
		if (fetch_out) begin
			status_q     <= STS_OK;
			seg_index_q  <= IDX_W'(lo);
			raw_index_q  <= rd_raw;
			seg_start_q  <= rd_start;
			pos_offset_q <= pos_q - rd_start;
		end else if (acc && !sctl.init) begin
			status_q     <= r_status;
			seg_index_q  <= r_seg_index;
			raw_index_q  <= r_raw_index;
			seg_start_q  <= r_seg_start;
			pos_offset_q <= '0;
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.status        = status_q;
	assign rsp.seg_index     = seg_index_q;
	assign rsp.raw_seg_index = raw_index_q;
	assign rsp.seg_start     = seg_start_q;
	assign rsp.pos_offset    = pos_offset_q;

`ifndef SYNTHESIS
	a_cnt_order: assert property (@(posedge clk) disable iff (!arst_n)
		aligned_cnt_q <= raw_cnt_q)
		else $error("aligned count exceeds raw count");
	a_cnt_limit: assert property (@(posedge clk) disable iff (!arst_n)
		raw_cnt_q <= CW'(MAX_SEGS))
		else $error("raw count past table depth");
	a_end_limit: assert property (@(posedge clk) disable iff (!arst_n)
		run_end_q <= END_W'(33'h1_0000_0000))
		else $error("running end past 2^32");
	a_search_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) && !slot_free |=> (state_q == ST_FETCH) && !ov_q == 1'b0)
		else $error("stalled search result lost");
`endif

endmodule
